@@ rtl/rational_add_sub_reduce_macros.svh @@
// Assertion macros shared by the rational add, subtract and reduce block.
`ifndef RATIONAL_ADD_SUB_REDUCE_MACROS_SVH
`define RATIONAL_ADD_SUB_REDUCE_MACROS_SVH

// Same-cycle implication, checked on every clock outside reset.
`define RASR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked on every clock outside reset.
`define RASR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/rasr_pkg.sv @@
// Package with the shared types and codes of the rational add, subtract and reduce block.
package rasr_pkg;

    // Operation kinds.
    localparam logic [1:0] KIND_NORM = 2'd0;
    localparam logic [1:0] KIND_ADD  = 2'd1;
    localparam logic [1:0] KIND_SUB  = 2'd2;
    localparam logic [1:0] KIND_EQ   = 2'd3;

    // Status codes.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    // Sequencer states of the top level.
    typedef enum logic [3:0] {
        S_IDLE,
        S_RA_GO,
        S_RA_WT,
        S_RB_GO,
        S_RB_WT,
        S_EQ,
        S_MUL,
        S_COMB,
        S_RR_GO,
        S_RR_WT,
        S_FIT,
        S_OUT
    } t_seq_state;

    // States of the reduction unit.
    typedef enum logic [2:0] {
        R_IDLE,
        R_GCD,
        R_SHL,
        R_DIV,
        R_DONE
    } t_red_state;

    // Status of the reduction unit seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } t_red_stat;

endpackage

@@ rtl/rasr_reduce.sv @@
// Reduction unit: binary GCD one step a cycle, then bit-serial exact division of both parts.
module rasr_reduce #(
    parameter int DW = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [DW-1:0]       i_mag,
    input  logic [DW-1:0]       i_den,
    output rasr_pkg::t_red_stat o_stat,
    output logic [DW-1:0]       o_mag,
    output logic [DW-1:0]       o_den
);

    localparam int KW = $clog2(DW + 1);
    localparam int CW = $clog2(DW);

    rasr_pkg::t_red_state r_state, n_state;

    logic [DW-1:0] r_x, r_y, r_g;
    logic [DW-1:0] r_m, r_d;
    logic [DW-1:0] r_rm, r_rd;
    logic [KW-1:0] r_k;
    logic [CW-1:0] r_cnt;

    logic [DW:0] w_tm, w_td;
    logic        w_qm, w_qd;

    // Trial subtraction for both dividends against the common divisor.
    always_comb begin
        w_tm = {r_rm, r_m[DW-1]};
        w_td = {r_rd, r_d[DW-1]};
        w_qm = (w_tm >= {1'b0, r_g});
        w_qd = (w_td >= {1'b0, r_g});
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            rasr_pkg::R_IDLE: begin
                if (i_start) begin
                    n_state = (i_mag == '0) ? rasr_pkg::R_DONE : rasr_pkg::R_GCD;
                end
            end
            rasr_pkg::R_GCD: begin
                if (r_x == r_y) begin
                    n_state = rasr_pkg::R_SHL;
                end
            end
            rasr_pkg::R_SHL: begin
                if (r_k == '0) begin
                    n_state = rasr_pkg::R_DIV;
                end
            end
            rasr_pkg::R_DIV: begin
                if (r_cnt == CW'(DW - 1)) begin
                    n_state = rasr_pkg::R_DONE;
                end
            end
            rasr_pkg::R_DONE: n_state = rasr_pkg::R_IDLE;
            default:          n_state = rasr_pkg::R_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_stat.busy = (r_state != rasr_pkg::R_IDLE);
        o_stat.done = (r_state == rasr_pkg::R_DONE);
        o_mag       = r_m;
        o_den       = r_d;
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rasr_pkg::R_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        case (r_state)
            rasr_pkg::R_IDLE: begin
                if (i_start) begin
                    r_x <= i_mag;
                    r_y <= i_den;
                    r_k <= '0;
                    if (i_mag == '0) begin
                        r_m <= '0;
                        r_d <= DW'(1);
                    end else begin
                        r_m <= i_mag;
                        r_d <= i_den;
                    end
                end
            end
            rasr_pkg::R_GCD: begin
                if (r_x == r_y) begin
                    r_g <= r_x;
                end else if (!r_x[0] && !r_y[0]) begin
                    r_x <= r_x >> 1;
                    r_y <= r_y >> 1;
                    r_k <= r_k + KW'(1);
                end else if (!r_x[0]) begin
                    r_x <= r_x >> 1;
                end else if (!r_y[0]) begin
                    r_y <= r_y >> 1;
                end else if (r_x > r_y) begin
                    r_x <= r_x - r_y;
                end else begin
                    r_y <= r_y - r_x;
                end
            end
            rasr_pkg::R_SHL: begin
                // Restore the common power of two, then clear the remainders.
                if (r_k != '0) begin
                    r_g <= r_g << 1;
                    r_k <= r_k - KW'(1);
                end
                r_rm  <= '0;
                r_rd  <= '0;
                r_cnt <= '0;
            end
            rasr_pkg::R_DIV: begin
                r_rm  <= w_qm ? DW'(w_tm - {1'b0, r_g}) : w_tm[DW-1:0];
                r_rd  <= w_qd ? DW'(w_td - {1'b0, r_g}) : w_td[DW-1:0];
                r_m   <= {r_m[DW-2:0], w_qm};
                r_d   <= {r_d[DW-2:0], w_qd};
                r_cnt <= r_cnt + CW'(1);
            end
            default: begin
            end
        endcase
    end

endmodule

@@ rtl/rational_add_sub_reduce.sv @@
// Sequence: a reduction runs a binary GCD, then divides both parts by it; normalize reduces a,
// equality reduces a and b and compares them, add and subtract reduce a and b, form the cross
// products and reduce the 2W-bit sum or difference.
// Throughput: one request at a time; the next request is taken once the sequencer is idle,
// while an earlier result may still wait in the output register.
// Reset (synchronous, active low) empties the sequencer, the reduction unit and the output.
module rational_add_sub_reduce #(
    parameter int WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_kind,
    input  logic signed [31:0] i_a_num,
    input  logic signed [31:0] i_a_den,
    input  logic signed [31:0] i_b_num,
    input  logic signed [31:0] i_b_den,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_result_num,
    output logic [30:0]        o_result_den,
    output logic               o_is_equal,
    output logic [1:0]         o_status
);

`include "rational_add_sub_reduce_macros.svh"

    localparam int D  = 2 * WIDTH;
    localparam int CW = $clog2(WIDTH);
    localparam logic [D-1:0] LIM = D'(1) << (WIDTH - 1);

    rasr_pkg::t_seq_state r_state, n_state;
    rasr_pkg::t_red_stat  red_stat;

    logic             red_start;
    logic [D-1:0]     red_in_mag, red_in_den, red_mag, red_den;

    logic [1:0]       r_kind;
    logic             r_aneg, r_bneg, r_neg;
    logic [WIDTH-1:0] r_amag, r_aden, r_bmag, r_bden;
    logic [D-1:0]     r_p, r_q, r_d, r_mcp, r_mcq, r_mcd;
    logic [WIDTH-1:0] r_mla, r_mlb;
    logic [CW-1:0]    r_cnt;

    logic [31:0]      r_res_num;
    logic [30:0]      r_res_den;
    logic             r_res_eq;
    logic [1:0]       r_res_st;

    logic             r_ovalid;
    logic [31:0]      r_onum;
    logic [30:0]      r_oden;
    logic             r_oeq;
    logic [1:0]       r_ost;

    logic [WIDTH-1:0] w_an, w_ad, w_bn, w_bd;
    logic [WIDTH-1:0] w_anm, w_adm, w_bnm, w_bdm;
    logic             w_zero, w_accept, w_yn, w_fneg, w_fit;
    logic [D-1:0]     w_fmag, w_fden;
    logic             w_out_zero, w_rr_done;

    // Split the low WIDTH bits of each operand into sign and magnitude.
    always_comb begin
        w_an  = i_a_num[WIDTH-1:0];
        w_ad  = i_a_den[WIDTH-1:0];
        w_bn  = i_b_num[WIDTH-1:0];
        w_bd  = i_b_den[WIDTH-1:0];
        w_anm = w_an[WIDTH-1] ? (WIDTH'(0) - w_an) : w_an;
        w_adm = w_ad[WIDTH-1] ? (WIDTH'(0) - w_ad) : w_ad;
        w_bnm = w_bn[WIDTH-1] ? (WIDTH'(0) - w_bn) : w_bn;
        w_bdm = w_bd[WIDTH-1] ? (WIDTH'(0) - w_bd) : w_bd;
        w_zero = (w_ad == '0) || ((i_kind != rasr_pkg::KIND_NORM) && (w_bd == '0));
    end

    // Sign of b as it enters the sum, and the range check of the final fraction.
    always_comb begin
        w_yn   = (r_bmag != '0) && (r_bneg != (r_kind == rasr_pkg::KIND_SUB));
        w_fmag = (r_kind == rasr_pkg::KIND_NORM) ? D'(r_amag) : red_mag;
        w_fden = (r_kind == rasr_pkg::KIND_NORM) ? D'(r_aden) : red_den;
        w_fneg = (r_kind == rasr_pkg::KIND_NORM) ? r_aneg : (r_neg && (red_mag != '0));
        w_fit  = (w_fden <= LIM - D'(1)) &&
                 (w_fneg ? (w_fmag <= LIM) : (w_fmag <= LIM - D'(1)));
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            rasr_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = w_zero ? rasr_pkg::S_OUT : rasr_pkg::S_RA_GO;
                end
            end
            rasr_pkg::S_RA_GO: n_state = rasr_pkg::S_RA_WT;
            rasr_pkg::S_RA_WT: begin
                if (red_stat.done) begin
                    n_state = (r_kind == rasr_pkg::KIND_NORM) ? rasr_pkg::S_FIT
                                                              : rasr_pkg::S_RB_GO;
                end
            end
            rasr_pkg::S_RB_GO: n_state = rasr_pkg::S_RB_WT;
            rasr_pkg::S_RB_WT: begin
                if (red_stat.done) begin
                    n_state = (r_kind == rasr_pkg::KIND_EQ) ? rasr_pkg::S_EQ
                                                            : rasr_pkg::S_MUL;
                end
            end
            rasr_pkg::S_EQ: n_state = rasr_pkg::S_OUT;
            rasr_pkg::S_MUL: begin
                if (r_cnt == CW'(WIDTH - 1)) begin
                    n_state = rasr_pkg::S_COMB;
                end
            end
            rasr_pkg::S_COMB:  n_state = rasr_pkg::S_RR_GO;
            rasr_pkg::S_RR_GO: n_state = rasr_pkg::S_RR_WT;
            rasr_pkg::S_RR_WT: begin
                if (red_stat.done) begin
                    n_state = rasr_pkg::S_FIT;
                end
            end
            rasr_pkg::S_FIT: n_state = rasr_pkg::S_OUT;
            rasr_pkg::S_OUT: begin
                if (!r_ovalid || !i_stall) begin
                    n_state = rasr_pkg::S_IDLE;
                end
            end
            default: n_state = rasr_pkg::S_IDLE;
        endcase
    end

    // Control outputs and the operand select of the reduction unit.
    always_comb begin
        o_stall    = (r_state != rasr_pkg::S_IDLE);
        red_start  = (r_state == rasr_pkg::S_RA_GO) || (r_state == rasr_pkg::S_RB_GO) ||
                     (r_state == rasr_pkg::S_RR_GO);
        red_in_mag = r_p;
        red_in_den = r_d;
        case (r_state)
            rasr_pkg::S_RA_GO: begin
                red_in_mag = D'(r_amag);
                red_in_den = D'(r_aden);
            end
            rasr_pkg::S_RB_GO: begin
                red_in_mag = D'(r_bmag);
                red_in_den = D'(r_bden);
            end
            default: begin
            end
        endcase
        w_accept = i_valid && !o_stall;
    end

    rasr_reduce #(
        .DW (D)
    ) u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (red_start),
        .i_mag   (red_in_mag),
        .i_den   (red_in_den),
        .o_stat  (red_stat),
        .o_mag   (red_mag),
        .o_den   (red_den)
    );

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rasr_pkg::S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == rasr_pkg::S_OUT && (!r_ovalid || !i_stall)) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            rasr_pkg::S_IDLE: begin
                if (w_accept) begin
                    r_kind    <= i_kind;
                    r_aneg    <= w_an[WIDTH-1] ^ w_ad[WIDTH-1];
                    r_amag    <= w_anm;
                    r_aden    <= w_adm;
                    r_bneg    <= w_bn[WIDTH-1] ^ w_bd[WIDTH-1];
                    r_bmag    <= w_bnm;
                    r_bden    <= w_bdm;
                    r_res_num <= '0;
                    r_res_den <= 31'(1);
                    r_res_eq  <= 1'b0;
                    r_res_st  <= w_zero ? rasr_pkg::ST_ZERO : rasr_pkg::ST_OK;
                end
            end
            rasr_pkg::S_RA_WT: begin
                if (red_stat.done) begin
                    r_amag <= red_mag[WIDTH-1:0];
                    r_aden <= red_den[WIDTH-1:0];
                    r_aneg <= r_aneg && (red_mag != '0);
                end
            end
            rasr_pkg::S_RB_WT: begin
                if (red_stat.done) begin
                    r_bmag <= red_mag[WIDTH-1:0];
                    r_bden <= red_den[WIDTH-1:0];
                    r_bneg <= r_bneg && (red_mag != '0);
                    // Load the three shift-add multipliers.
                    r_mcp  <= D'(r_amag);
                    r_mcd  <= D'(r_aden);
                    r_mcq  <= D'(red_mag[WIDTH-1:0]);
                    r_mlb  <= red_den[WIDTH-1:0];
                    r_mla  <= r_aden;
                    r_p    <= '0;
                    r_q    <= '0;
                    r_d    <= '0;
                    r_cnt  <= '0;
                end
            end
            rasr_pkg::S_EQ: begin
                r_res_eq <= (r_aneg == r_bneg) && (r_amag == r_bmag) && (r_aden == r_bden);
            end
            rasr_pkg::S_MUL: begin
                // One multiplier bit per cycle for each of the cross products.
                if (r_mlb[0]) begin
                    r_p <= r_p + r_mcp;
                    r_d <= r_d + r_mcd;
                end
                if (r_mla[0]) begin
                    r_q <= r_q + r_mcq;
                end
                r_mcp <= r_mcp << 1;
                r_mcd <= r_mcd << 1;
                r_mcq <= r_mcq << 1;
                r_mlb <= r_mlb >> 1;
                r_mla <= r_mla >> 1;
                r_cnt <= r_cnt + CW'(1);
            end
            rasr_pkg::S_COMB: begin
                // Signed sum in sign and magnitude form.
                if (r_aneg == w_yn) begin
                    r_p   <= r_p + r_q;
                    r_neg <= r_aneg;
                end else if (r_p >= r_q) begin
                    r_p   <= r_p - r_q;
                    r_neg <= r_aneg;
                end else begin
                    r_p   <= r_q - r_p;
                    r_neg <= w_yn;
                end
            end
            rasr_pkg::S_FIT: begin
                if (w_fit) begin
                    r_res_num <= w_fneg ? (32'(0) - 32'(w_fmag[WIDTH-1:0]))
                                        : 32'(w_fmag[WIDTH-1:0]);
                    r_res_den <= 31'(w_fden[WIDTH-1:0]);
                end else begin
                    r_res_st <= rasr_pkg::ST_OVF;
                end
            end
            rasr_pkg::S_OUT: begin
                if (!r_ovalid || !i_stall) begin
                    r_onum <= r_res_num;
                    r_oden <= r_res_den;
                    r_oeq  <= r_res_eq;
                    r_ost  <= r_res_st;
                end
            end
            default: begin
            end
        endcase
    end

    // Output ports.
    assign o_valid      = r_ovalid;
    assign o_result_num = r_onum;
    assign o_result_den = r_oden;
    assign o_is_equal   = r_oeq;
    assign o_status     = r_ost;

    // Terms used by the checks below.
    assign w_out_zero = (o_result_num == 32'sd0) && (o_result_den == 31'd1);
    assign w_rr_done  = (r_state == rasr_pkg::S_RR_WT) && red_stat.done;

    // Checks on the sequencer and the result register.
    `RASR_ASSERT_NOW(a_red_start_idle, red_start, !red_stat.busy)
    `RASR_ASSERT_NOW(a_fail_zero_result, o_valid && (o_status != rasr_pkg::ST_OK), w_out_zero)
    `RASR_ASSERT_NOW(a_equal_ok, o_valid && o_is_equal, o_status == rasr_pkg::ST_OK)
    `RASR_ASSERT_NEXT(a_done_advances, w_rr_done, r_state == rasr_pkg::S_FIT)

endmodule
